// ===== rtl/core/posf_pkg.sv =====
// Shared constants, payload structs and control structs of the ping/offset slew filter.
`default_nettype none
package posf_pkg;

  localparam int WINDOW_DEPTH = 10;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int SUM_W        = 32 + $clog2(WINDOW_DEPTH);
  localparam int DIV_CNT_W    = $clog2(SUM_W);

  localparam logic OP_QUERY   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [22:0]        elapsed_us;
    logic [22:0]        ping_us;
    logic signed [31:0] offset_us;
  } in_t;

  typedef struct packed {
    logic signed [31:0] smoothed_offset_us;
    logic signed [31:0] smoothed_ping_us;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic slew;
    logic scan_init;
    logic scan_step;
    logic prep;
    logic div_step;
    logic tgt_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic skip_targets;
    logic scan_last;
    logic div_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/ping_offset_slew_filter.sv =====
// Each transaction passes through the multiply, slew and emit states before its result
// is valid; a query or first measurement then returns to idle, while a later
// measurement adds a scan of the window entries, a setup state, a restoring divide and
// a target write. A stalled result holds the block in the emit state.
// Reset (synchronous, rst high) clears the window count and pointer and sets the
// smoothed values and targets to -1 and the slew rate to 66.
`default_nettype none
module ping_offset_slew_filter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire posf_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output posf_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [15:0]    cfg_data
);

  posf_pkg::cmd_t  cmd;
  posf_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  posf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Arithmetic and state.
  posf_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/posf_ctrl.sv =====
// Sequencing state machine of the ping/offset slew filter.
`default_nettype none
module posf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output posf_pkg::cmd_t      cmd,
  input  wire posf_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SLEW, S_EMIT, S_SCAN, S_PREP, S_DIV, S_TGT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Commands decoded from the current state and the input and output handshakes.
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.mul       = (state == S_MUL);
    cmd.slew      = (state == S_SLEW);
    cmd.out_load  = (state == S_EMIT) && out_free;
    cmd.scan_init = (state == S_EMIT) && out_free;
    cmd.scan_step = (state == S_SCAN);
    cmd.prep      = (state == S_PREP);
    cmd.div_step  = (state == S_DIV);
    cmd.tgt_write = (state == S_TGT);
  end

  // State register and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_valid) state <= S_MUL;
        S_MUL:  state <= S_SLEW;
        S_SLEW: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) state <= stat.skip_targets ? S_IDLE : S_SCAN;
        end
        S_SCAN: if (stat.scan_last) state <= S_PREP;
        S_PREP: state <= S_DIV;
        S_DIV:  if (stat.div_last) state <= S_TGT;
        S_TGT:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/posf_dpath.sv =====
// Datapath of the ping/offset slew filter: window, smoothing, scan and divider.
`default_nettype none
module posf_dpath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire posf_pkg::in_t   in_data,
  input  wire logic            cfg_valid,
  input  wire logic [15:0]     cfg_data,
  input  wire posf_pkg::cmd_t  cmd,
  output posf_pkg::stat_t      stat,
  output posf_pkg::out_t       out_data
);

  localparam int D  = posf_pkg::WINDOW_DEPTH;
  localparam int CW = posf_pkg::CNT_W;
  localparam int PW = posf_pkg::PTR_W;
  localparam int SW = posf_pkg::SUM_W;
  localparam logic signed [SW:0] MAX32 = (SW+1)'(32'sh7fffffff);
  localparam logic signed [SW:0] MIN32 = (SW+1)'(32'sh80000000);

  posf_pkg::in_t      in_r;
  posf_pkg::out_t     res;
  logic [15:0]        rate;
  logic [22:0]        step;
  logic signed [31:0] win_off [D];
  logic [22:0]        win_ping [D];
  logic [CW-1:0]      count;
  logic [PW-1:0]      wp;
  logic signed [31:0] last_off, last_ping, tgt_off, tgt_ping;
  logic               skip;

  logic [PW-1:0]      pos, idx, lo_p, hi_p, lo_o, hi_o;
  logic signed [SW-1:0] sum_p, min_p, max_p, sum_o, min_o, max_o;
  logic [SW-1:0]      q_p, q_o;
  logic               neg_p, neg_o;
  logic [CW-1:0]      rem_p, rem_o, divisor;
  logic [posf_pkg::DIV_CNT_W-1:0] div_cnt;

  // Move a value toward its target by at most one step, stopping at the target.
  function automatic logic signed [31:0] slew_fn(input logic signed [31:0] v,
                                                 input logic signed [31:0] t,
                                                 input logic [22:0] s);
    logic signed [33:0] r;
    logic signed [33:0] t34;
    logic               up;
    up  = t > v;
    t34 = 34'(t);
    r   = up ? 34'(v) + $signed({11'b0, s}) : 34'(v) - $signed({11'b0, s});
    if (up && r > t34) r = t34;
    if (!up && r < t34) r = t34;
    return r[31:0];
  endfunction

  // Signed result of the divider, clamped to 32 bits.
  function automatic logic signed [31:0] sat_fn(input logic n, input logic [SW-1:0] q);
    logic signed [SW:0] v;
    v = n ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > MAX32) v = MAX32;
    if (v < MIN32) v = MIN32;
    return v[31:0];
  endfunction

  logic signed [31:0] sl_off, sl_ping;
  logic               first;
  logic               tp_pos;
  logic [PW:0]        start_sum;
  logic [PW-1:0]      start;
  logic [CW-1:0]      count_next;
  logic signed [SW-1:0] ve_p, ve_o;
  logic signed [SW-1:0] num_p, num_o;
  logic [CW:0]        sh_p, sh_o;
  logic [CW:0]        dv;

  assign sl_off  = slew_fn(last_off, tgt_off, step);
  assign sl_ping = slew_fn(last_ping, tgt_ping, step);
  assign first   = last_ping[31];
  assign tp_pos  = !tgt_ping[31] && (tgt_ping != 32'sd0);

  // Oldest entry of the window once this measurement is stored.
  assign start_sum = (PW+1)'(wp) + (PW+1)'(D) - (PW+1)'(count);
  assign start     = (start_sum >= (PW+1)'(D)) ? PW'(start_sum - (PW+1)'(D))
                                               : start_sum[PW-1:0];
  assign count_next = (count < CW'(D)) ? count + 1'b1 : count;

  // Current window entry, widened for the sums.
  assign ve_p = $signed({{(SW-23){1'b0}}, win_ping[pos]});
  assign ve_o = {{(SW-32){win_off[pos][31]}}, win_off[pos]};

  // Trimmed numerators from three entries on; the first minimum and maximum drop out only once each.
  always_comb begin
    if (count < CW'(3)) begin
      num_p = sum_p;
      num_o = sum_o;
    end else begin
      num_p = sum_p - min_p - ((lo_p == hi_p) ? '0 : max_p);
      num_o = sum_o - min_o - ((lo_o == hi_o) ? '0 : max_o);
    end
  end

  // One restoring division step per cycle on each channel.
  assign dv   = {1'b0, divisor};
  assign sh_p = {rem_p, q_p[SW-1]};
  assign sh_o = {rem_o, q_o[SW-1]};

  assign stat.skip_targets = skip;
  assign stat.scan_last    = (CW'(idx) == count - CW'(1));
  assign stat.div_last     = (div_cnt == posf_pkg::DIV_CNT_W'(SW - 1));

  // Control registers: rate, window bookkeeping and smoothed state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate      <= 16'd66;
      count     <= '0;
      wp        <= '0;
      last_off  <= -32'sd1;
      last_ping <= -32'sd1;
      tgt_off   <= -32'sd1;
      tgt_ping  <= -32'sd1;
    end else begin
      if (cfg_valid) rate <= cfg_data;
      if (cmd.slew && in_r.operation == posf_pkg::OP_MEASURE) begin
        wp    <= (wp == PW'(D - 1)) ? '0 : wp + 1'b1;
        count <= count_next;
        if (first) begin
          last_off  <= in_r.offset_us;
          last_ping <= {9'b0, in_r.ping_us};
        end else if (tp_pos) begin
          last_off  <= sl_off;
          last_ping <= sl_ping;
        end
      end
      if (cmd.tgt_write) begin
        tgt_ping <= sat_fn(neg_p, q_p);
        tgt_off  <= sat_fn(neg_o, q_o);
      end
    end
  end

  // Payload registers: input, step, window, results, scan and divider.
  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.mul) step <= 23'((39'(in_r.elapsed_us) * 39'(rate)) >> 16);
    if (cmd.slew) begin
      if (in_r.operation == posf_pkg::OP_QUERY) begin
        res.smoothed_offset_us <= sl_off;
        res.smoothed_ping_us   <= sl_ping;
        skip <= 1'b1;
      end else begin
        win_off[wp]  <= in_r.offset_us;
        win_ping[wp] <= in_r.ping_us;
        skip <= first;
        if (first) begin
          res.smoothed_offset_us <= in_r.offset_us;
          res.smoothed_ping_us   <= {9'b0, in_r.ping_us};
        end else if (tp_pos) begin
          res.smoothed_offset_us <= sl_off;
          res.smoothed_ping_us   <= sl_ping;
        end else begin
          res.smoothed_offset_us <= last_off;
          res.smoothed_ping_us   <= last_ping;
        end
      end
    end
    // The staged result moves to the output only once the output is free.
    if (cmd.out_load) out_data <= res;
    if (cmd.scan_init) begin
      pos   <= start;
      idx   <= '0;
      sum_p <= '0;
      sum_o <= '0;
    end
    if (cmd.scan_step) begin
      pos   <= (pos == PW'(D - 1)) ? '0 : pos + 1'b1;
      idx   <= idx + 1'b1;
      sum_p <= sum_p + ve_p;
      sum_o <= sum_o + ve_o;
      if (idx == '0 || ve_p < min_p) begin
        min_p <= ve_p;
        lo_p  <= idx;
      end
      if (idx == '0 || ve_p > max_p) begin
        max_p <= ve_p;
        hi_p  <= idx;
      end
      if (idx == '0 || ve_o < min_o) begin
        min_o <= ve_o;
        lo_o  <= idx;
      end
      if (idx == '0 || ve_o > max_o) begin
        max_o <= ve_o;
        hi_o  <= idx;
      end
    end
    if (cmd.prep) begin
      neg_p   <= num_p[SW-1];
      neg_o   <= num_o[SW-1];
      q_p     <= num_p[SW-1] ? SW'(-num_p) : SW'(num_p);
      q_o     <= num_o[SW-1] ? SW'(-num_o) : SW'(num_o);
      rem_p   <= '0;
      rem_o   <= '0;
      divisor <= (count < CW'(3)) ? count : count - CW'(2);
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (sh_p >= dv) begin
        rem_p <= CW'(sh_p - dv);
        q_p   <= {q_p[SW-2:0], 1'b1};
      end else begin
        rem_p <= sh_p[CW-1:0];
        q_p   <= {q_p[SW-2:0], 1'b0};
      end
      if (sh_o >= dv) begin
        rem_o <= CW'(sh_o - dv);
        q_o   <= {q_o[SW-2:0], 1'b1};
      end else begin
        rem_o <= sh_o[CW-1:0];
        q_o   <= {q_o[SW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/posf_checker.sv =====
// Port-level assertions of the ping/offset slew filter and their bind.
`default_nettype none
module posf_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire posf_pkg::out_t out_data
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An accepted transaction keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transaction");

  // A new result only appears after the block was busy, never straight out of idle.
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ping_offset_slew_filter posf_checker u_posf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== test/ping_offset_slew_filter_tb.sv =====
// Self-checking testbench of the ping/offset slew filter with a behavioral predictor.
`default_nettype none
module ping_offset_slew_filter_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  posf_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  posf_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  ping_offset_slew_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Filter state mirrored by the predictor.
  longint offset_hist[posf_pkg::WINDOW_DEPTH];
  longint ping_hist[posf_pkg::WINDOW_DEPTH];
  int hist_count;
  int hist_ptr;
  longint smooth_offset;
  longint smooth_ping;
  longint goal_offset;
  longint goal_ping;
  longint rate;

  posf_pkg::out_t pending_smoothed[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  int hold_len = 0;

  localparam int IDLE_LIMIT = 5000;

  // Moves a value toward its target by the elapsed-time step, stopping at the target.
  function automatic longint slewed(longint v, longint t, longint e);
    longint step;
    longint r;
    step = (e * rate) >>> 16;
    if (t > v) begin
      r = v + step;
      if (r > t) r = t;
    end else begin
      r = v - step;
      if (r < t) r = t;
    end
    return r;
  endfunction

  // Mean of one history, trimmed from three entries on, oldest first, saturated to 32 bits.
  function automatic longint window_mean(bit use_ping);
    longint seq[posf_pkg::WINDOW_DEPTH];
    int lo;
    int hi;
    int idx;
    longint sum;
    longint q;
    lo = 0;
    hi = 0;
    sum = 0;
    if (hist_count == 0) return -1;
    idx = (hist_ptr + posf_pkg::WINDOW_DEPTH - hist_count) % posf_pkg::WINDOW_DEPTH;
    for (int i = 0; i < hist_count; i++) begin
      seq[i] = use_ping ? ping_hist[idx] : offset_hist[idx];
      idx = (idx + 1) % posf_pkg::WINDOW_DEPTH;
    end
    if (hist_count < 3) begin
      for (int i = 0; i < hist_count; i++) sum += seq[i];
      q = sum / hist_count;
    end else begin
      for (int i = 1; i < hist_count; i++) begin
        if (seq[i] < seq[lo]) lo = i;
        if (seq[i] > seq[hi]) hi = i;
      end
      for (int i = 0; i < hist_count; i++)
        if (i != lo && i != hi) sum += seq[i];
      q = sum / (hist_count - 2);
    end
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // Computes the expected smoothed pair of one transaction and updates the state.
  function automatic posf_pkg::out_t predict_smoothed(posf_pkg::in_t item);
    posf_pkg::out_t r;
    longint e;
    e = longint'(item.elapsed_us);
    if (item.operation == posf_pkg::OP_QUERY) begin
      r.smoothed_offset_us = 32'(slewed(smooth_offset, goal_offset, e));
      r.smoothed_ping_us = 32'(slewed(smooth_ping, goal_ping, e));
      return r;
    end
    offset_hist[hist_ptr] = longint'(item.offset_us);
    ping_hist[hist_ptr] = longint'(item.ping_us);
    hist_ptr = (hist_ptr + 1) % posf_pkg::WINDOW_DEPTH;
    if (hist_count < posf_pkg::WINDOW_DEPTH) hist_count++;
    if (smooth_ping < 0) begin
      smooth_offset = longint'(item.offset_us);
      smooth_ping = longint'(item.ping_us);
    end else begin
      if (goal_ping > 0) begin
        smooth_offset = slewed(smooth_offset, goal_offset, e);
        smooth_ping = slewed(smooth_ping, goal_ping, e);
      end
      goal_ping = window_mean(1'b1);
      goal_offset = window_mean(1'b0);
    end
    r.smoothed_offset_us = 32'(smooth_offset);
    r.smoothed_ping_us = 32'(smooth_ping);
    return r;
  endfunction

  // Sends one transaction after a random gap and records its expected result.
  task automatic send_item(posf_pkg::in_t item);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    in_data = item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_smoothed = {pending_smoothed, predict_smoothed(item)};
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every expected result has arrived and the block is quiet.
  task automatic drain();
    while (pending_smoothed.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Writes the slew rate while the block is idle.
  task automatic write_rate(logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rate = longint'(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic posf_pkg::in_t make_item(logic op, logic [22:0] e, logic [22:0] p,
                                              logic [31:0] o);
    posf_pkg::in_t t;
    t.operation = op;
    t.elapsed_us = e;
    t.ping_us = p;
    t.offset_us = o;
    return t;
  endfunction

  function automatic posf_pkg::in_t random_item();
    posf_pkg::in_t t;
    t.operation = ($urandom_range(0, 3) != 0) ? posf_pkg::OP_MEASURE : posf_pkg::OP_QUERY;
    case ($urandom_range(0, 3))
      0: t.elapsed_us = 23'($urandom);
      1: t.elapsed_us = 23'h7FFFFF;
      default: t.elapsed_us = 23'($urandom_range(0, 600000));
    endcase
    case ($urandom_range(0, 3))
      0: t.ping_us = 23'($urandom);
      1: t.ping_us = 23'($urandom_range(0, 3));
      default: t.ping_us = 23'($urandom_range(1000, 80000));
    endcase
    case ($urandom_range(0, 4))
      0: t.offset_us = $urandom;
      1: t.offset_us = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: t.offset_us = 32'($urandom_range(0, 200000)) - 32'd100000;
    endcase
    return t;
  endfunction

  // Queries before any measurement, then the first few measurements and field extremes.
  task automatic test_directed();
    send_item(make_item(posf_pkg::OP_QUERY, 23'd0, 23'd0, 32'd0));
    send_item(make_item(posf_pkg::OP_QUERY, 23'h7FFFFF, 23'h7FFFFF, 32'hFFFFFFFF));
    send_item(make_item(posf_pkg::OP_MEASURE, 23'd500000, 23'd20000, 32'd1000));
    send_item(make_item(posf_pkg::OP_QUERY, 23'd500000, 23'd0, 32'd0));
    send_item(make_item(posf_pkg::OP_MEASURE, 23'h7FFFFF, 23'd30000, -32'sd500));
    send_item(make_item(posf_pkg::OP_MEASURE, 23'd1000, 23'd0, 32'h80000000));
    send_item(make_item(posf_pkg::OP_MEASURE, 23'd0, 23'h7FFFFF, 32'h7FFFFFFF));
    send_item(make_item(posf_pkg::OP_QUERY, 23'h7FFFFF, 23'd0, 32'd0));
    // Equal entries, so minimum and maximum are the same entry.
    repeat (12) send_item(make_item(posf_pkg::OP_MEASURE, 23'd5000, 23'd777, 32'h80000000));
    send_item(make_item(posf_pkg::OP_QUERY, 23'd123, 23'd0, 32'd0));
    send_item(make_item(posf_pkg::OP_MEASURE, 23'h555555, 23'h2AAAAA, 32'h55555555));
    send_item(make_item(posf_pkg::OP_MEASURE, 23'h2AAAAA, 23'h555555, 32'hAAAAAAAA));
    drain();
  endtask

  // Random traffic at one slew setting.
  task automatic test_random(int count, logic [15:0] setting);
    write_rate(setting);
    for (int i = 0; i < count; i++) send_item(random_item());
    drain();
  endtask

  // Receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_len = 400;
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) send_item(random_item());
    drain();
  endtask

  // Receiver: random stall per result, with quiet stretches and a long hold-off.
  initial begin
    int wait_cycles;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall = 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_off = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_cycles != 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    posf_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_smoothed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: offset %0d ping %0d",
                   out_data.smoothed_offset_us, out_data.smoothed_ping_us);
      end else begin
        want = pending_smoothed.pop_front();
        if (want.smoothed_offset_us !== out_data.smoothed_offset_us ||
            want.smoothed_ping_us !== out_data.smoothed_ping_us) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected offset %0d ping %0d, got offset %0d ping %0d",
                     want.smoothed_offset_us, want.smoothed_ping_us,
                     out_data.smoothed_offset_us, out_data.smoothed_ping_us);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("ping_offset_slew_filter test failed");
      $finish;
    end
  end

  initial begin
    hist_count = 0;
    hist_ptr = 0;
    smooth_offset = -1;
    smooth_ping = -1;
    goal_offset = -1;
    goal_ping = -1;
    rate = 66;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300, 16'd66);
    test_random(300, 16'hFFFF);
    test_random(200, 16'd0);
    test_backpressure();
    test_random(500, 16'($urandom));
    test_random(500, 16'd1);
    if (mismatches == 0 && pending_smoothed.size() == 0)
      $display("ping_offset_slew_filter test passed");
    else
      $display("ping_offset_slew_filter test failed");
    $finish;
  end

endmodule
`default_nettype wire
